// ===== sv/refcounted_handle_table_top_macros.svh =====
// assertion macros for the refcounted handle table
`ifndef REFCOUNTED_HANDLE_TABLE_TOP_MACROS_SVH
`define REFCOUNTED_HANDLE_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define RHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rht check failed");

// next-cycle implication, checked outside reset
`define RHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rht check failed");

`endif

// ===== sv/rht_pkg.sv =====
// shared types, constants and helpers of the refcounted handle table
`default_nettype none

package rht_pkg;

  localparam int LOG2_SLOTS  = 6;
  localparam int NSLOTS      = 1 << LOG2_SLOTS;
  localparam int COUNT_BITS  = 16;
  localparam int TAG_BITS    = 16;
  localparam int HANDLE_BITS = 31;

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
  localparam logic [HANDLE_BITS-1:0] HANDLE_MAX = '1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_DISCARD = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  count;
    logic [TAG_BITS-1:0]    tag;
    logic [HANDLE_BITS-1:0] handle;
  } slot_t;

  typedef struct packed {
    logic                  re;
    logic                  we;
    logic [LOG2_SLOTS-1:0] addr;
    slot_t                 wdata;
  } mem_req_t;

  typedef struct packed {
    status_e                status;
    logic [HANDLE_BITS-1:0] handle;
    logic [TAG_BITS-1:0]    object;
    logic                   destroy;
  } res_t;

  // running handle counter: 1 .. max, then back to 1
  function automatic logic [HANDLE_BITS-1:0] advance_handle(
    input logic [HANDLE_BITS-1:0] h
  );
    logic [HANDLE_BITS-1:0] n;
    if (h == HANDLE_MAX || h == '0) begin
      n = HANDLE_BITS'(1);
    end else begin
      n = h + HANDLE_BITS'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/refcounted_handle_table_top.sv =====
// top level: refcounted handle table with stream ports and output register
// lookup and discard read the slot when the item is accepted, then evaluate it and
// register the result; allocate first probes k busy slots before a free one (k <= 63)
// throughput: one item at a time, lookup and discard bounded by the
//   single-port slot memory read then write-back; allocate probes one slot a cycle
// reset: asynchronous active low, all slots free at once, next handle returns to 1
`default_nettype none

module refcounted_handle_table_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input item
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [30:0] handle_in, [46:31] object_tag, [47] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // result item
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,   // [30:0] handle_out, [46:31] object_out, [47] zero
  output logic      [2:0]  m_axis_tuser    // [1:0] status, [2] destroy
);

  rht_pkg::mem_req_t req;
  rht_pkg::slot_t    entry;
  rht_pkg::res_t     res;
  logic              res_valid;
  logic              out_free;

  // output register: result held here while the sink stalls
  logic              out_valid_q;
  rht_pkg::res_t     out_q;

  assign out_free = !out_valid_q || m_axis_tready;

  rht_slot_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .entry_o(entry)
  );

  // sequencer owns the handle counter and the probe loop
  rht_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_opcode_i(s_axis_tuser),
    .in_handle_i(s_axis_tdata[30:0]),
    .in_tag_i   (s_axis_tdata[46:31]),
    .out_free_i (out_free),
    .req_o      (req),
    .entry_i    (entry),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.object, out_q.handle};
  assign m_axis_tuser  = {out_q.destroy, out_q.status};

endmodule

`default_nettype wire

// ===== sv/rht_ram.sv =====
// generic single-port ram with registered read
`default_nettype none

module rht_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/rht_slot_store.sv =====
// slot memory with per-entry written bits so unwritten slots read as free
`default_nettype none

module rht_slot_store (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rht_pkg::mem_req_t  req_i,
  output rht_pkg::slot_t          entry_o
);

  logic [rht_pkg::NSLOTS-1:0]     written_q;
  logic [rht_pkg::LOG2_SLOTS-1:0] raddr_q;
  logic [$bits(rht_pkg::slot_t)-1:0] rdata;
  rht_pkg::slot_t                 raw;

  rht_ram #(
    .Width($bits(rht_pkg::slot_t)),
    .Depth(rht_pkg::NSLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .re_i   (req_i.re),
    .we_i   (req_i.we),
    .addr_i (req_i.addr),
    .wdata_i(req_i.wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      raddr_q   <= '0;
    end else begin
      if (req_i.we) begin
        written_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        raddr_q <= req_i.addr;
      end
    end
  end

  // a slot never written counts as free
  always_comb begin
    raw     = rdata;
    entry_o = raw;
    if (!written_q[raddr_q]) begin
      entry_o.count = '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rht_seq.sv =====
// sequencer: read-modify-write of one slot per item, allocate probe loop
`default_nettype none

`include "refcounted_handle_table_top_macros.svh"

module rht_seq (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        in_opcode_i,
  input  wire logic [rht_pkg::HANDLE_BITS-1:0]   in_handle_i,
  input  wire logic [rht_pkg::TAG_BITS-1:0]      in_tag_i,
  input  wire logic                              out_free_i,
  output rht_pkg::mem_req_t                      req_o,
  input  wire rht_pkg::slot_t                    entry_i,
  output logic                                   res_valid_o,
  output rht_pkg::res_t                          res_o
);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  state_e                          state_q, state_d;
  logic [1:0]                      op_q, op_d;
  logic [rht_pkg::HANDLE_BITS-1:0] handle_q, handle_d;
  logic [rht_pkg::TAG_BITS-1:0]    tag_q, tag_d;
  logic [rht_pkg::LOG2_SLOTS-1:0]  tries_q, tries_d;
  logic [rht_pkg::HANDLE_BITS-1:0] next_handle_q, next_handle_d;

  logic [rht_pkg::HANDLE_BITS-1:0] adv;
  logic                            live;
  logic                            match;

  assign adv   = rht_pkg::advance_handle(next_handle_q);
  assign live  = entry_i.count != '0;
  assign match = live && (handle_q != '0) && (entry_i.handle == handle_q);

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    handle_d      = handle_q;
    tag_d         = tag_q;
    tries_d       = tries_q;
    next_handle_d = next_handle_q;
    in_ready_o    = 1'b0;
    req_o         = '0;
    res_valid_o   = 1'b0;
    res_o         = '0;
    res_o.status  = rht_pkg::ST_INVALID;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = in_opcode_i;
          handle_d = in_handle_i;
          tag_d    = in_tag_i;
          tries_d  = '0;
          req_o.re = 1'b1;
          if (in_opcode_i == rht_pkg::OP_ALLOC) begin
            req_o.addr = next_handle_q[rht_pkg::LOG2_SLOTS-1:0];
          end else begin
            req_o.addr = in_handle_i[rht_pkg::LOG2_SLOTS-1:0];
          end
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        case (op_q)
          rht_pkg::OP_ALLOC: begin
            if (!live) begin
              if (out_free_i) begin
                req_o.we           = 1'b1;
                req_o.addr         = next_handle_q[rht_pkg::LOG2_SLOTS-1:0];
                req_o.wdata.count  = rht_pkg::COUNT_BITS'(1);
                req_o.wdata.tag    = tag_q;
                req_o.wdata.handle = next_handle_q;
                res_o.status       = rht_pkg::ST_OK;
                res_o.handle       = next_handle_q;
                res_valid_o        = 1'b1;
                next_handle_d      = adv;
                state_d            = S_IDLE;
              end
            end else if (tries_q != '1) begin
              // slot taken: probe the next candidate
              next_handle_d = adv;
              tries_d       = tries_q + 1'b1;
              req_o.re      = 1'b1;
              req_o.addr    = adv[rht_pkg::LOG2_SLOTS-1:0];
            end else if (out_free_i) begin
              res_o.status  = rht_pkg::ST_FULL;
              res_valid_o   = 1'b1;
              next_handle_d = adv;
              state_d       = S_IDLE;
            end
          end
          rht_pkg::OP_LOOKUP: begin
            if (out_free_i) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
              if (match) begin
                if (entry_i.count == rht_pkg::COUNT_MAX) begin
                  res_o.status = rht_pkg::ST_SATURATED;
                end else begin
                  req_o.we          = 1'b1;
                  req_o.addr        = handle_q[rht_pkg::LOG2_SLOTS-1:0];
                  req_o.wdata       = entry_i;
                  req_o.wdata.count = entry_i.count + 1'b1;
                  res_o.status      = rht_pkg::ST_OK;
                  res_o.object      = entry_i.tag;
                end
              end
            end
          end
          rht_pkg::OP_DISCARD: begin
            if (out_free_i) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
              if (match && entry_i.tag == tag_q) begin
                req_o.we          = 1'b1;
                req_o.addr        = handle_q[rht_pkg::LOG2_SLOTS-1:0];
                req_o.wdata       = entry_i;
                req_o.wdata.count = entry_i.count - 1'b1;
                res_o.status      = rht_pkg::ST_OK;
                if (entry_i.count == rht_pkg::COUNT_BITS'(1)) begin
                  req_o.wdata.tag    = '0;
                  req_o.wdata.handle = '0;
                  res_o.destroy      = 1'b1;
                end
              end
            end
          end
          default: begin
            if (out_free_i) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= '0;
      handle_q      <= '0;
      tag_q         <= '0;
      tries_q       <= '0;
      next_handle_q <= rht_pkg::HANDLE_BITS'(1);
    end else begin
      state_q       <= state_d;
      op_q          <= op_d;
      handle_q      <= handle_d;
      tag_q         <= tag_d;
      tries_q       <= tries_d;
      next_handle_q <= next_handle_d;
    end
  end

  `RHT_ASSERT_NOW(a_rd_wr_excl, 1'b1, !(req_o.re && req_o.we))
  `RHT_ASSERT_NOW(a_handle_nonzero, 1'b1, next_handle_q != '0)
  `RHT_ASSERT_NOW(a_res_needs_room, res_valid_o, out_free_i)
  `RHT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

endmodule

`default_nettype wire
